### hdl/mgt_pkg.sv
`default_nettype none

package mgt_pkg;

   // Default size of the position range.
   localparam int POSITIONS_DEFAULT = 4096;

   // Fixed field widths of the channels.
   localparam int POS_W  = 12;
   localparam int GAP_W  = 13;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   localparam logic [GAP_W-1:0] SPAN_RESET = 13'd4096;

   // Bitmaps are stored and searched one 64-bit word at a time.
   localparam int WORD_BITS = 64;
   localparam int WB        = 6;

   // Opcodes of the request channel.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   // Status codes of the response channel.
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_REMOVE,
      KIND_REPORT,
      KIND_RANGE
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [POS_W-1:0]     pos;
   } item_type;

   // Index of the highest set bit (zero when the word is empty).
   function automatic logic [WB-1:0] hi_bit(input logic [WORD_BITS-1:0] d);
      logic [WB-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (d[i]) r = WB'(i);
      end
      return r;
   endfunction

   // Index of the lowest set bit (zero when the word is empty).
   function automatic logic [WB-1:0] lo_bit(input logic [WORD_BITS-1:0] d);
      logic [WB-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (d[i]) r = WB'(i);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/mgt_queue.sv
`default_nettype none

module mgt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  wire mgt_pkg::item_type in_item,
   output logic              out_valid,
   input  wire               out_ready,
   output mgt_pkg::item_type out_item
);
   import mgt_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

### hdl/mgt_front.sv
`default_nettype none

module mgt_front #(
   parameter int LW = 13
) (
   input  wire                           hold,
   input  wire  [LW-1:0]                 eff_width,
   input  wire                           in_valid,
   output logic                          in_ready,
   input  wire  [mgt_pkg::OP_W-1:0]      in_opcode,
   input  wire  [mgt_pkg::POS_W-1:0]     in_pos,
   output logic                          q_valid,
   input  wire                           q_ready,
   output mgt_pkg::item_type             q_item
);
   import mgt_pkg::*;

   logic out_of_span;

   // Boundaries themselves and anything at or past the right end are rejected.
   assign out_of_span = (in_pos == '0) || (32'(in_pos) >= 32'(eff_width));

   assign in_ready = q_ready && !hold;
   assign q_valid  = in_valid && !hold;

   always_comb begin
      q_item.pos = in_pos;
      unique case (in_opcode)
         OP_INSERT: q_item.kind = out_of_span ? KIND_RANGE : KIND_INSERT;
         OP_REMOVE: q_item.kind = out_of_span ? KIND_RANGE : KIND_REMOVE;
         default:   q_item.kind = KIND_REPORT;
      endcase
   end

endmodule

`default_nettype wire

### hdl/mgt_engine.sv
`default_nettype none

module mgt_engine #(
   parameter int POSITIONS = mgt_pkg::POSITIONS_DEFAULT,
   parameter int LW        = 13
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            restart,
   input  wire  [LW-1:0]                  eff_width,
   output logic                           clearing,
   input  wire                            q_valid,
   output logic                           q_pop,
   input  wire mgt_pkg::item_type         q_item,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [mgt_pkg::GAP_W-1:0]      rsp_max,
   output logic [mgt_pkg::STAT_W-1:0]     rsp_status
);
   import mgt_pkg::*;

   localparam int WORDS = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
   localparam int NZW   = (POSITIONS + WORD_BITS) / WORD_BITS;
   localparam int OAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int NAW   = (NZW > 1) ? $clog2(NZW) : 1;
   localparam int SW    = (OAW > NAW) ? OAW : NAW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHK, S_LISS, S_LCHK, S_RSTART, S_RISS, S_RCHK,
      S_URD, S_UWR, S_OWR, S_MISS, S_MCHK, S_DONE
   } state_type;

   // Occupancy bitmap, gap counters by length, and a bitmap of nonzero counters.
   logic [WORD_BITS-1:0] occ_mem [WORDS];
   logic [LW-1:0]        cnt_mem [POSITIONS+1];
   logic [WORD_BITS-1:0] nz_mem  [NZW];

   logic [WORD_BITS-1:0] occ_rd_ff, nz_rd_ff;
   logic [LW-1:0]        cnt_rd_ff;

   logic                 occ_we, cnt_we, nz_we;
   logic [OAW-1:0]       occ_waddr, occ_raddr;
   logic [LW-1:0]        cnt_waddr, cnt_raddr;
   logic [NAW-1:0]       nz_waddr, nz_raddr;
   logic [WORD_BITS-1:0] occ_wdata, nz_wdata;
   logic [LW-1:0]        cnt_wdata;

   state_type            state_ff;
   kind_type             kind_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [STAT_W-1:0]    status_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [SW-1:0]        waddr_ff;
   logic [LW-1:0]        left_ff, right_ff, len_ff, idx_ff;
   logic [1:0]           step_ff;
   logic                 inc_ff;
   logic [GAP_W-1:0]     max_ff;
   logic                 rsp_valid_ff;
   logic [GAP_W-1:0]     rsp_max_ff;
   logic [STAT_W-1:0]    rsp_status_ff;

   logic [WB-1:0]        pos_bit;
   logic [OAW-1:0]       pos_word;
   logic [WORD_BITS-1:0] below_mask, above_mask, lm, rm, scan_lm;
   logic [LW-1:0]        pos_l, len_in, new_cnt;
   logic                 inc_in;
   logic                 rsp_load;

   assign pos_bit    = pos_ff[WB-1:0];
   assign pos_word   = OAW'(pos_ff >> WB);
   assign pos_l      = LW'(pos_ff);
   assign below_mask = (WORD_BITS'(1) << pos_bit) - WORD_BITS'(1);
   assign above_mask = ~((WORD_BITS'(2) << pos_bit) - WORD_BITS'(1));
   // Position zero is the left boundary and always counts as occupied.
   assign lm      = (occ_rd_ff & below_mask) | ((pos_word == '0) ? WORD_BITS'(1) : '0);
   assign rm      = word_ff & above_mask;
   assign scan_lm = occ_rd_ff | ((waddr_ff == '0) ? WORD_BITS'(1) : '0);

   // A finished result moves to the output register once that register is free.
   assign rsp_load = (state_ff == S_DONE) && !restart && (!rsp_valid_ff || rsp_ready);

   // The three counter updates of an insert or a remove, in order.
   always_comb begin
      len_in = right_ff - left_ff;
      inc_in = 1'b0;
      if (kind_ff == KIND_INSERT) begin
         unique case (step_ff)
            2'd0:    begin len_in = right_ff - left_ff; inc_in = 1'b0; end
            2'd1:    begin len_in = pos_l - left_ff;    inc_in = 1'b1; end
            default: begin len_in = right_ff - pos_l;   inc_in = 1'b1; end
         endcase
      end else begin
         unique case (step_ff)
            2'd0:    begin len_in = pos_l - left_ff;    inc_in = 1'b0; end
            2'd1:    begin len_in = right_ff - pos_l;   inc_in = 1'b0; end
            default: begin len_in = right_ff - left_ff; inc_in = 1'b1; end
         endcase
      end
   end

   always_comb begin
      if (inc_ff)                new_cnt = cnt_rd_ff + LW'(1);
      else if (cnt_rd_ff != '0)  new_cnt = cnt_rd_ff - LW'(1);
      else                       new_cnt = cnt_rd_ff;
   end

   always_comb begin
      occ_we    = 1'b0;
      cnt_we    = 1'b0;
      nz_we     = 1'b0;
      occ_waddr = pos_word;
      occ_wdata = word_ff ^ (WORD_BITS'(1) << pos_bit);
      cnt_waddr = len_ff;
      cnt_wdata = new_cnt;
      nz_waddr  = NAW'(len_ff >> WB);
      nz_wdata  = nz_rd_ff;
      nz_wdata[WB'(len_ff)] = (new_cnt != '0);
      occ_raddr = OAW'(waddr_ff);
      cnt_raddr = len_in;
      nz_raddr  = NAW'(waddr_ff);
      unique case (state_ff)
         S_CLEAR: begin
            occ_we    = (32'(idx_ff) < WORDS);
            occ_waddr = OAW'(idx_ff);
            occ_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff;
            cnt_wdata = (idx_ff == eff_width) ? LW'(1) : '0;
            nz_we     = (32'(idx_ff) < NZW);
            nz_waddr  = NAW'(idx_ff);
            nz_wdata  = (32'(idx_ff) == 32'(eff_width >> WB)) ?
                        (WORD_BITS'(1) << WB'(eff_width)) : '0;
         end
         S_IDLE:  occ_raddr = OAW'(q_item.pos >> WB);
         S_URD:   nz_raddr  = NAW'(len_in >> WB);
         S_UWR: begin
            cnt_we = 1'b1;
            nz_we  = 1'b1;
         end
         S_OWR:   occ_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      occ_rd_ff <= occ_mem[occ_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (nz_we) nz_mem[nz_waddr] <= nz_wdata;
      nz_rd_ff <= nz_mem[nz_raddr];
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_max    = rsp_max_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load)                       rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (restart) begin
            state_ff <= S_CLEAR;
            idx_ff   <= '0;
         end else begin
            unique case (state_ff)
               S_CLEAR: begin
                  idx_ff <= idx_ff + LW'(1);
                  if (32'(idx_ff) == POSITIONS) state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  if (q_valid) begin
                     kind_ff  <= q_item.kind;
                     pos_ff   <= q_item.pos;
                     step_ff  <= 2'd0;
                     waddr_ff <= SW'(eff_width >> WB);
                     unique case (q_item.kind)
                        KIND_INSERT, KIND_REMOVE: state_ff <= S_CHK;
                        KIND_RANGE: begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_MISS;
                        end
                        default: begin
                           status_ff <= ST_OK;
                           state_ff  <= S_MISS;
                        end
                     endcase
                  end
               end
               S_CHK: begin
                  word_ff   <= occ_rd_ff;
                  status_ff <= ST_OK;
                  if (kind_ff == KIND_INSERT && occ_rd_ff[pos_bit]) begin
                     status_ff <= ST_PRESENT;
                     state_ff  <= S_MISS;
                  end else if (kind_ff == KIND_REMOVE && !occ_rd_ff[pos_bit]) begin
                     status_ff <= ST_ABSENT;
                     state_ff  <= S_MISS;
                  end else if (lm != '0) begin
                     left_ff  <= LW'((32'(pos_word) << WB) | 32'(hi_bit(lm)));
                     state_ff <= S_RSTART;
                  end else begin
                     waddr_ff <= SW'(pos_word) - SW'(1);
                     state_ff <= S_LISS;
                  end
               end
               S_LISS: state_ff <= S_LCHK;
               S_LCHK: begin
                  if (scan_lm != '0) begin
                     left_ff  <= LW'((32'(waddr_ff) << WB) | 32'(hi_bit(scan_lm)));
                     state_ff <= S_RSTART;
                  end else begin
                     waddr_ff <= waddr_ff - SW'(1);
                     state_ff <= S_LISS;
                  end
               end
               S_RSTART: begin
                  if (rm != '0) begin
                     right_ff <= LW'((32'(pos_word) << WB) | 32'(lo_bit(rm)));
                     state_ff <= S_URD;
                  end else if (32'(pos_word) == WORDS - 1) begin
                     right_ff <= eff_width;
                     state_ff <= S_URD;
                  end else begin
                     waddr_ff <= SW'(pos_word) + SW'(1);
                     state_ff <= S_RISS;
                  end
               end
               S_RISS: state_ff <= S_RCHK;
               S_RCHK: begin
                  if (occ_rd_ff != '0) begin
                     right_ff <= LW'((32'(waddr_ff) << WB) | 32'(lo_bit(occ_rd_ff)));
                     state_ff <= S_URD;
                  end else if (32'(waddr_ff) == WORDS - 1) begin
                     right_ff <= eff_width;
                     state_ff <= S_URD;
                  end else begin
                     waddr_ff <= waddr_ff + SW'(1);
                     state_ff <= S_RISS;
                  end
               end
               S_URD: begin
                  len_ff   <= len_in;
                  inc_ff   <= inc_in;
                  state_ff <= S_UWR;
               end
               S_UWR: begin
                  step_ff <= step_ff + 2'd1;
                  if (step_ff == 2'd2) state_ff <= S_OWR;
                  else                 state_ff <= S_URD;
               end
               S_OWR: begin
                  waddr_ff <= SW'(eff_width >> WB);
                  state_ff <= S_MISS;
               end
               S_MISS: state_ff <= S_MCHK;
               S_MCHK: begin
                  if (nz_rd_ff != '0) begin
                     max_ff   <= GAP_W'((32'(waddr_ff) << WB) | 32'(hi_bit(nz_rd_ff)));
                     state_ff <= S_DONE;
                  end else if (waddr_ff == '0) begin
                     max_ff   <= GAP_W'(eff_width);
                     state_ff <= S_DONE;
                  end else begin
                     waddr_ff <= waddr_ff - SW'(1);
                     state_ff <= S_MISS;
                  end
               end
               S_DONE: begin
                  if (rsp_load) begin
                     rsp_max_ff    <= max_ff;
                     rsp_status_ff <= status_ff;
                     state_ff      <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### hdl/max_gap_tracker.sv
// Maximum-gap tracker over a set of cut positions inside the span 0..span_width.
// Requests arrive on the req_ stream: tuser carries the opcode (insert, remove,
// report) and tdata the position. Every request beat yields exactly one response
// beat on the rsp_ stream with the largest gap after the request and a status.
// span_width is written through csr_we/csr_wdata; a write empties the set.
// A classifier in front checks the span and queues two requests; the engine
// behind it walks the occupancy bitmap one 64-bit word at a time to find
// both neighbours, updates three gap counters by read-modify-write, and then
// walks the bitmap of nonzero counters downward for the maximum.
// The engine takes the next request only after the previous one has finished.
// After reset and after each span_width write a clearing pass runs; req_tready
// stays low during it. When the receiver stalls, the finished response waits
// in the output register and the queue keeps taking requests until it is full.
`default_nettype none

module max_gap_tracker #(
   parameter int POSITIONS = mgt_pkg::POSITIONS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel. tdata: position [11:0], zero padding [15:12].
   // tuser: opcode [1:0].
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   input  wire  [1:0]  req_tuser,
   // Response channel. tdata: max_gap [12:0], status [14:13], zero [15].
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,
   // Configuration: span_width.
   input  wire         csr_we,
   input  wire  [12:0] csr_wdata
);
   import mgt_pkg::*;

   // Gap lengths run up to POSITIONS.
   localparam int LW = $clog2(POSITIONS + 1);

   logic [GAP_W-1:0]  span_ff, span_in;
   logic [LW-1:0]     eff_ff, eff_in;
   logic              clearing;
   logic              fq_valid, fq_ready;
   item_type          fq_item;
   logic              eq_valid, eq_pop;
   item_type          eq_item;
   logic [GAP_W-1:0]  rsp_max;
   logic [STAT_W-1:0] rsp_status;

   // The effective width clamps the register into 1..POSITIONS.
   always_comb begin
      span_in = csr_we ? csr_wdata : span_ff;
      if (span_in == '0)                 eff_in = LW'(1);
      else if (32'(span_in) > POSITIONS) eff_in = LW'(POSITIONS);
      else                               eff_in = LW'(span_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= SPAN_RESET;
         eff_ff  <= (32'(SPAN_RESET) > POSITIONS) ? LW'(POSITIONS) : LW'(SPAN_RESET);
      end else begin
         span_ff <= span_in;
         eff_ff  <= eff_in;
      end
   end

   mgt_front #(.LW(LW)) u_front (
      .hold      (clearing),
      .eff_width (eff_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (req_tuser),
      .in_pos    (req_tdata[POS_W-1:0]),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_item    (fq_item)
   );

   mgt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (eq_valid),
      .out_ready (eq_pop),
      .out_item  (eq_item)
   );

   mgt_engine #(.POSITIONS(POSITIONS), .LW(LW)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .eff_width  (eff_ff),
      .clearing   (clearing),
      .q_valid    (eq_valid),
      .q_pop      (eq_pop),
      .q_item     (eq_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_max    (rsp_max),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {1'b0, rsp_status, rsp_max};

   // No request may be taken while the stores are being cleared.
   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_tready)
      else $error("request accepted during clearing pass");

   // A width write always starts a clearing pass.
   assert property (@(posedge clock) disable iff (reset) csr_we |=> clearing)
      else $error("width write did not start clearing");

   // The largest gap is never zero.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> rsp_tdata[12:0] != '0)
      else $error("zero maximum gap reported");

endmodule

`default_nettype wire

### verif/gap_checker.sv
`default_nettype none

module gap_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [15:0] req_tdata,
   input  wire  [1:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [12:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);
   import mgt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPOS = POSITIONS_DEFAULT;

   bit                 cut_map [NPOS];
   int unsigned        gap_tally [NPOS+1];
   int unsigned        width_eff;
   logic [GAP_W-1:0]   gap_expected [$];
   logic [STAT_W-1:0]  stat_expected [$];

   function automatic void empty_set(input logic [12:0] w);
      width_eff = (w == 0) ? 1 : ((w > NPOS) ? NPOS : w);
      foreach (cut_map[i]) cut_map[i] = 0;
      foreach (gap_tally[i]) gap_tally[i] = 0;
      gap_tally[width_eff] = 1;
   endfunction

   function automatic int unsigned left_cut(input int unsigned p);
      while (p > 0) begin
         p--;
         if (p == 0 || cut_map[p]) return p;
      end
      return 0;
   endfunction

   function automatic int unsigned right_cut(input int unsigned p);
      while (p + 1 < width_eff) begin
         p++;
         if (cut_map[p]) return p;
      end
      return width_eff;
   endfunction

   function automatic void tally_down(input int unsigned len);
      if (len <= NPOS && gap_tally[len] > 0) gap_tally[len]--;
   endfunction

   function automatic void tally_up(input int unsigned len);
      if (len <= NPOS) gap_tally[len]++;
   endfunction

   function automatic int unsigned widest_gap();
      for (int unsigned len = width_eff; len > 0; len--)
         if (gap_tally[len] != 0) return len;
      return width_eff;
   endfunction

   // Apply one request beat and queue the response it must produce.
   function automatic void apply_request(input logic [1:0] op, input logic [11:0] pos);
      logic [STAT_W-1:0] st;
      int unsigned l, r;
      st = ST_OK;
      if (op == OP_INSERT || op == OP_REMOVE) begin
         if (pos == 0 || pos >= width_eff) begin
            st = ST_RANGE;
         end else if (op == OP_INSERT) begin
            if (cut_map[pos]) begin
               st = ST_PRESENT;
            end else begin
               l = left_cut(pos);
               r = right_cut(pos);
               tally_down(r - l);
               tally_up(pos - l);
               tally_up(r - pos);
               cut_map[pos] = 1;
            end
         end else begin
            if (!cut_map[pos]) begin
               st = ST_ABSENT;
            end else begin
               l = left_cut(pos);
               r = right_cut(pos);
               tally_down(pos - l);
               tally_down(r - pos);
               tally_up(r - l);
               cut_map[pos] = 0;
            end
         end
      end
      gap_expected  = {gap_expected, GAP_W'(widest_gap())};
      stat_expected = {stat_expected, st};
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_seen = 0;
      pending = 0;
      empty_set(SPAN_RESET);
   end

   always @(posedge clock) begin
      if (reset) begin
         empty_set(SPAN_RESET);
      end else begin
         if (csr_we) empty_set(csr_wdata);
         if (req_tvalid && req_tready) apply_request(req_tuser, req_tdata[11:0]);
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (gap_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected response %h", rsp_tdata));
            end else begin
               if (rsp_tdata[12:0] !== gap_expected[0])
                  report_mismatch($sformatf("max_gap %0d, expected %0d",
                                            rsp_tdata[12:0], gap_expected[0]));
               if (rsp_tdata[14:13] !== stat_expected[0])
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tdata[14:13], stat_expected[0]));
               if (rsp_tdata[15] !== 1'b0)
                  report_mismatch("padding bit of the response is set");
               void'(gap_expected.pop_front());
               void'(stat_expected.pop_front());
            end
         end
      end
      pending = gap_expected.size();
   end

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

// Stimulus and verdict for the maximum-gap tracker. The checker beside the
// block predicts every response; this module only drives beats and decides.
module tb_top;
   import mgt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [12:0] csr_wdata = '0;

   int          fail_count;
   int          pending;
   int          rsp_seen;
   longint      cycle_count = 0;

   // Idle percentages of the two sides; the receiver can also be held off.
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          recv_hold = 1'b0;
   int unsigned width_now = SPAN_RESET;

   // Positions believed occupied, kept so that removes mostly hit.
   logic [11:0] placed [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   max_gap_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   gap_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .rsp_seen   (rsp_seen)
   );

   // Watchdog: the clearing pass after each width write plus worst-case
   // scans for every item, taken with a wide margin.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, or solidly while a hold is requested.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Send one request beat, with a random idle gap in front of it. The
   // valid line is only lowered when an idle cycle really follows.
   task automatic send_beat(input logic [1:0] op, input logic [11:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, pos};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every response, then a pause; write_width below then rewrites the span width.
   // The write empties the set and starts a clearing pass in the block.
   task automatic drain();
      end_burst();
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_width(input logic [12:0] w);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      width_now = (w == 0) ? 1 : ((w > POSITIONS_DEFAULT) ? POSITIONS_DEFAULT : w);
      placed.delete();
   endtask

   // Mostly well-formed traffic: inserts of random in-span positions, removes of
   // placed ones, reports, and a share of errors, out-of-span values and
   // the unused opcode.
   task automatic random_beats(input int count);
      int          pick;
      int          idx;
      logic [11:0] pos;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         pos  = (width_now > 1) ? 12'($urandom_range(width_now - 1, 1)) : 12'd1;
         if (pick < 45) begin
            send_beat(OP_INSERT, pos);
            placed = {placed, pos};
         end else if (pick < 75 && placed.size() > 0) begin
            idx = $urandom_range(placed.size() - 1);
            send_beat(OP_REMOVE, placed[idx]);
            placed.delete(idx);
         end else if (pick < 85) begin
            send_beat(OP_REPORT, 12'($urandom));
         end else if (pick < 90) begin
            send_beat(2'd3, 12'($urandom));
         end else begin
            // Noise: any opcode with any 12-bit position.
            send_beat(2'($urandom_range(3)), 12'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset width: bounds, duplicates, absent removes,
      // every opcode including the unused one.
      send_idle_pct = 33;
      recv_idle_pct = 72;
      send_beat(OP_REPORT, 12'hFFF);
      send_beat(OP_INSERT, 12'd0);
      send_beat(OP_INSERT, 12'hFFF);
      send_beat(OP_INSERT, 12'hFFF);
      send_beat(OP_INSERT, 12'd1);
      send_beat(OP_INSERT, 12'd2048);
      send_beat(OP_INSERT, 12'd2048);
      send_beat(OP_REMOVE, 12'd5);
      send_beat(OP_REMOVE, 12'd0);
      send_beat(OP_REMOVE, 12'd2048);
      send_beat(2'd3, 12'd7);
      send_beat(OP_REMOVE, 12'hFFF);
      send_beat(OP_REMOVE, 12'd1);
      send_beat(OP_INSERT, 12'hAAA);
      send_beat(OP_INSERT, 12'h555);

      // Smallest spans: zero is taken as one, so every cut is out of span.
      write_width(13'd0);
      send_beat(OP_INSERT, 12'd1);
      send_beat(OP_REPORT, 12'd0);
      write_width(13'd2);
      send_beat(OP_INSERT, 12'd1);
      send_beat(OP_INSERT, 12'd2);
      send_beat(OP_REMOVE, 12'd1);
      // Above the position range: taken as the full range.
      write_width(13'h1FFF);
      send_beat(OP_INSERT, 12'hFFF);
      send_beat(OP_REPORT, 12'd0);

      // Random phases over several widths, small ones dominating.
      write_width(13'd100);
      random_beats(350);
      write_width(13'd4096);
      random_beats(250);

      // Back-pressure: the receiver holds off for a long stretch while
      // requests keep coming, so the block's queue fills and stalls.
      fork
         begin
            recv_hold = 1'b1;
            repeat (3000) @(posedge clock);
            recv_hold = 1'b0;
         end
         random_beats(40);
      join

      send_idle_pct = 72;
      recv_idle_pct = 33;
      write_width(13'd37);
      random_beats(300);
      write_width(13'd1000);
      random_beats(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_width(13'd3);
      random_beats(150);
      write_width(13'd300);
      random_beats(350);
      drain();

      $display("Covered %0d responses across widths from the minimum to the full range,",
               rsp_seen);
      $display("with errors, unused opcodes, random stalls and a long receiver hold.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
